[sv/fvg_pkg.sv]
// ============================================================================
// fvg_pkg
// Shared types and constants for the FAT volume geometry decoder.
// ============================================================================
package fvg_pkg;

    // Boot sector geometry constants
    localparam int unsigned SECTOR_SIZE    = 'h200;
    localparam int unsigned DIR_ENTRY_SIZE = 'h20;
    localparam int unsigned DIR_PER_SECTOR = SECTOR_SIZE / DIR_ENTRY_SIZE;
    localparam int unsigned DIR_SHIFT      = $clog2(DIR_PER_SECTOR);
    localparam int unsigned FAT12_LIMIT    = 4085;
    localparam int unsigned FAT16_LIMIT    = 65525;
    localparam int unsigned EOC_FAT16      = 'hfff;
    localparam int unsigned EOC_FAT32      = 'hffffff;

    // Divider geometry: 32-bit dividend, 8-bit divisor
    localparam int unsigned DIVIDEND_W         = 32;
    localparam int unsigned DIVISOR_W          = 8;
    localparam int unsigned DIV_BITS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES         = DIVIDEND_W / DIV_BITS_PER_STAGE;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_SECTOR   = 2'd1,
        ST_FAT12        = 2'd2,
        ST_ZERO_CLUSTER = 2'd3
    } fvg_status_t;

    typedef enum logic [1:0] {
        KIND_FAT12 = 2'd0,
        KIND_FAT16 = 2'd1,
        KIND_FAT32 = 2'd2,
        KIND_NONE  = 2'd3
    } fvg_kind_t;

    // Unpacked boot sector fields
    typedef struct packed {
        logic [15:0] sector_bytes;
        logic [7:0]  sectors_per_cluster;
        logic [15:0] reserved_sectors;
        logic [7:0]  fat_count;
        logic [15:0] root_entries;
        logic [15:0] total_sectors_short;
        logic [31:0] total_sectors_long;
        logic [15:0] fat_sectors_short;
        logic [31:0] fat_sectors_long;
        logic [31:0] root_first_cluster;
        logic [31:0] partition_start;
    } fvg_bpb_t;

    // Values that ride alongside the cluster division
    typedef struct packed {
        fvg_status_t status;
        logic [31:0] fat_start;
        logic [31:0] root_cluster;
        logic [31:0] after_fats;
        logic [31:0] data_start16;
        logic [12:0] dir_sectors;
    } fvg_side_t;

    // One result transfer
    typedef struct packed {
        fvg_status_t status;
        fvg_kind_t   fat_kind;
        logic [31:0] cluster_total;
        logic [31:0] fat_start;
        logic [31:0] root_start;
        logic [31:0] data_start;
        logic [12:0] root_dir_sectors;
        logic [23:0] end_mark;
    } fvg_result_t;

endpackage

[sv/fvg_front.sv]
// ============================================================================
// fvg_front
// Three-stage front end: field select, FAT area product, area sums and the
// data sector count ahead of the cluster division.
// ============================================================================
module fvg_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fvg_pkg::fvg_bpb_t      in_bpb,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            out_data_sectors,
    output logic [7:0]             out_spc,
    output fvg_pkg::fvg_side_t     out_side
);

    // Stage 1 registers
    logic               v1_reg;
    fvg_pkg::fvg_status_t st1_reg, st1_next;
    logic [31:0]        vol1_reg, vol1_next;
    logic [31:0]        fats1_reg, fats1_next;
    logic [12:0]        dir1_reg, dir1_next;
    logic [31:0]        fstart1_reg, fstart1_next;
    logic [15:0]        resv1_reg;
    logic [7:0]         spc1_reg;
    logic [31:0]        rclu1_reg;

    // Stage 2 registers
    logic               v2_reg;
    fvg_pkg::fvg_status_t st2_reg;
    logic [31:0]        vol2_reg;
    logic [31:0]        area2_reg, area2_next;
    logic [31:0]        after2_reg, after2_next;
    logic [12:0]        dir2_reg;
    logic [7:0]         spc2_reg;
    logic [31:0]        rclu2_reg;
    logic [31:0]        fstart2_reg;

    // Stage 3 registers
    logic               v3_reg;
    fvg_pkg::fvg_status_t st3_reg;
    logic [31:0]        data3_reg, data3_next;
    logic [31:0]        ds16_3_reg, ds16_3_next;
    logic [31:0]        after3_reg;
    logic [12:0]        dir3_reg;
    logic [7:0]         spc3_reg;
    logic [31:0]        rclu3_reg;
    logic [31:0]        fstart3_reg;

    logic rdy1, rdy2, rdy3;
    logic [31:0] fat_size;

    // Stall chain
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: pick short or long fields, FAT area product, root dir size
    always_comb
    begin
        fat_size = (in_bpb.fat_sectors_short != 16'd0) ?
                   {16'd0, in_bpb.fat_sectors_short} : in_bpb.fat_sectors_long;
        vol1_next = (in_bpb.total_sectors_short != 16'd0) ?
                    {16'd0, in_bpb.total_sectors_short} : in_bpb.total_sectors_long;
        fats1_next   = fat_size * {24'd0, in_bpb.fat_count};
        dir1_next    = 13'((17'(in_bpb.root_entries) + 17'(fvg_pkg::DIR_PER_SECTOR - 1))
                           >> fvg_pkg::DIR_SHIFT);
        fstart1_next = in_bpb.partition_start + {16'd0, in_bpb.reserved_sectors};
        if (in_bpb.sector_bytes != 16'(fvg_pkg::SECTOR_SIZE))
            st1_next = fvg_pkg::ST_BAD_SECTOR;
        else if (in_bpb.sectors_per_cluster == 8'd0)
            st1_next = fvg_pkg::ST_ZERO_CLUSTER;
        else
            st1_next = fvg_pkg::ST_OK;
    end

    // Stage 2: total sectors ahead of the data area and end of the FAT copies
    always_comb
    begin
        area2_next  = {16'd0, resv1_reg} + fats1_reg + {19'd0, dir1_reg};
        after2_next = fstart1_reg + fats1_reg;
    end

    // Stage 3: data sectors and FAT16 data start
    always_comb
    begin
        data3_next  = vol2_reg - area2_reg;
        ds16_3_next = after2_reg + {19'd0, dir2_reg};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            st1_reg     <= st1_next;
            vol1_reg    <= vol1_next;
            fats1_reg   <= fats1_next;
            dir1_reg    <= dir1_next;
            fstart1_reg <= fstart1_next;
            resv1_reg   <= in_bpb.reserved_sectors;
            spc1_reg    <= in_bpb.sectors_per_cluster;
            rclu1_reg   <= in_bpb.root_first_cluster;
        end
        if (rdy2 && v1_reg)
        begin
            st2_reg     <= st1_reg;
            vol2_reg    <= vol1_reg;
            area2_reg   <= area2_next;
            after2_reg  <= after2_next;
            dir2_reg    <= dir1_reg;
            spc2_reg    <= spc1_reg;
            rclu2_reg   <= rclu1_reg;
            fstart2_reg <= fstart1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            st3_reg     <= st2_reg;
            data3_reg   <= data3_next;
            ds16_3_reg  <= ds16_3_next;
            after3_reg  <= after2_reg;
            dir3_reg    <= dir2_reg;
            spc3_reg    <= spc2_reg;
            rclu3_reg   <= rclu2_reg;
            fstart3_reg <= fstart2_reg;
        end
    end

    assign out_valid        = v3_reg;
    assign out_data_sectors = data3_reg;
    assign out_spc          = spc3_reg;

    always_comb
    begin
        out_side.status       = st3_reg;
        out_side.fat_start    = fstart3_reg;
        out_side.root_cluster = rclu3_reg;
        out_side.after_fats   = after3_reg;
        out_side.data_start16 = ds16_3_reg;
        out_side.dir_sectors  = dir3_reg;
    end

endmodule

[sv/fvg_div.sv]
// ============================================================================
// fvg_div
// Pipelined restoring divider, 32-bit dividend by 8-bit divisor, a fixed
// number of quotient bits per stage; side data travels with each item.
// ============================================================================
module fvg_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fvg_pkg::DIVIDEND_W-1:0]       in_dividend,
    input  logic [fvg_pkg::DIVISOR_W-1:0]        in_divisor,
    input  fvg_pkg::fvg_side_t                   in_side,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fvg_pkg::DIVIDEND_W-1:0]       out_quotient,
    output fvg_pkg::fvg_side_t                   out_side
);

    localparam int unsigned N  = fvg_pkg::DIV_STAGES;
    localparam int unsigned DW = fvg_pkg::DIVIDEND_W;
    localparam int unsigned VW = fvg_pkg::DIVISOR_W;

    logic [N-1:0]       valid_reg;
    logic [N-1:0]       stage_ready;
    logic [VW-1:0]      rem_reg  [N];
    logic [DW-1:0]      work_reg [N];
    logic [VW-1:0]      dvs_reg  [N];
    fvg_pkg::fvg_side_t side_reg [N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic               src_valid;
            logic [VW-1:0]      src_rem;
            logic [DW-1:0]      src_work;
            logic [VW-1:0]      src_dvs;
            fvg_pkg::fvg_side_t src_side;
            logic [VW-1:0]      rem_next;
            logic [DW-1:0]      work_next;

            // Source: port for the first stage, previous stage otherwise
            if (g == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_rem   = '0;
                assign src_work  = in_dividend;
                assign src_dvs   = in_divisor;
                assign src_side  = in_side;
            end
            else
            begin : g_mid
                assign src_valid = valid_reg[g-1];
                assign src_rem   = rem_reg[g-1];
                assign src_work  = work_reg[g-1];
                assign src_dvs   = dvs_reg[g-1];
                assign src_side  = side_reg[g-1];
            end

            // Stall chain
            if (g == N - 1)
            begin : g_last
                assign stage_ready[g] = !valid_reg[g] || out_ready;
            end
            else
            begin : g_inner
                assign stage_ready[g] = !valid_reg[g] || stage_ready[g+1];
            end

            // Shift-subtract steps; quotient bits enter the work word from the bottom
            always_comb
            begin : p_steps
                logic [VW:0] r_ext;
                logic        q_bit;
                rem_next  = src_rem;
                work_next = src_work;
                for (int s = 0; s < int'(fvg_pkg::DIV_BITS_PER_STAGE); s++)
                begin
                    r_ext = {rem_next, work_next[DW-1]};
                    q_bit = (r_ext >= {1'b0, src_dvs});
                    if (q_bit)
                        rem_next = VW'(r_ext - {1'b0, src_dvs});
                    else
                        rem_next = r_ext[VW-1:0];
                    work_next = {work_next[DW-2:0], q_bit};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else if (stage_ready[g])
                    valid_reg[g] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[g] && src_valid)
                begin
                    rem_reg[g]  <= rem_next;
                    work_reg[g] <= work_next;
                    dvs_reg[g]  <= src_dvs;
                    side_reg[g] <= src_side;
                end
            end
        end
    endgenerate

    assign in_ready     = stage_ready[0];
    assign out_valid    = valid_reg[N-1];
    assign out_quotient = work_reg[N-1];
    assign out_side     = side_reg[N-1];

endmodule

[sv/fvg_back.sv]
// ============================================================================
// fvg_back
// Final stage: classify by cluster count and register the result transfer.
// ============================================================================
module fvg_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           in_clusters,
    input  fvg_pkg::fvg_side_t    in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fvg_pkg::fvg_result_t  out_result
);

    logic                 valid_reg;
    fvg_pkg::fvg_result_t res_reg, res_next;

    assign in_ready = !valid_reg || out_ready;

    // Classification and field selection
    always_comb
    begin
        res_next = '0;
        res_next.status   = in_side.status;
        res_next.fat_kind = fvg_pkg::KIND_FAT12;
        if (in_side.status == fvg_pkg::ST_OK)
        begin
            res_next.cluster_total    = in_clusters;
            res_next.fat_start        = in_side.fat_start;
            res_next.root_dir_sectors = in_side.dir_sectors;
            if (in_clusters < 32'(fvg_pkg::FAT12_LIMIT))
            begin
                res_next.status = fvg_pkg::ST_FAT12;
            end
            else if (in_clusters < 32'(fvg_pkg::FAT16_LIMIT))
            begin
                res_next.fat_kind   = fvg_pkg::KIND_FAT16;
                res_next.root_start = in_side.after_fats;
                res_next.data_start = in_side.data_start16;
                res_next.end_mark   = 24'(fvg_pkg::EOC_FAT16);
            end
            else
            begin
                res_next.fat_kind   = fvg_pkg::KIND_FAT32;
                res_next.root_start = in_side.root_cluster;
                res_next.data_start = in_side.after_fats;
                res_next.end_mark   = 24'(fvg_pkg::EOC_FAT32);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= res_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = res_reg;

endmodule

[sv/fat_volume_geometry.sv]
// ============================================================================
// fat_volume_geometry
// FAT boot sector geometry decoder: cluster count, FAT type and area starts.
// ============================================================================
// Takes one boot sector's geometry fields per transfer and returns one result
// per transfer, in order. One transfer can be taken every clock cycle while
// the output is not stalled. An input transfer passes through three front-end
// stages (field select and FAT area product, area sums, data sector count),
// eight stages of the restoring divider that produces four quotient bits of
// the cluster count per stage, and one classification and output register
// stage. Backpressure stalls only the stages that hold data, so empty slots
// are filled while the output waits.
// ============================================================================
module fat_volume_geometry (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // sector_bytes[15:0], sectors_per_cluster[23:16], reserved_sectors[39:24],
    // fat_count[47:40], root_entries[63:48], total_sectors_short[79:64],
    // total_sectors_long[111:80], fat_sectors_short[127:112],
    // fat_sectors_long[159:128], root_first_cluster[191:160],
    // partition_start[223:192]
    input  logic [223:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // cluster_total[31:0], fat_start[63:32], root_start[95:64],
    // data_start[127:96], root_dir_sectors[140:128], end_mark[164:141], zero pad
    output logic [167:0]  m_tdata,
    // status[1:0], fat_kind[3:2]
    output logic [3:0]    m_tuser
);

    fvg_pkg::fvg_bpb_t    bpb;
    fvg_pkg::fvg_side_t   fr_side, dv_side;
    fvg_pkg::fvg_result_t result;
    logic                 fr_valid, fr_ready, dv_valid, dv_ready;
    logic [31:0]          fr_data_sectors, dv_quotient;
    logic [7:0]           fr_spc;

    // Input unpacking
    always_comb
    begin
        bpb.sector_bytes        = s_tdata[15:0];
        bpb.sectors_per_cluster = s_tdata[23:16];
        bpb.reserved_sectors    = s_tdata[39:24];
        bpb.fat_count           = s_tdata[47:40];
        bpb.root_entries        = s_tdata[63:48];
        bpb.total_sectors_short = s_tdata[79:64];
        bpb.total_sectors_long  = s_tdata[111:80];
        bpb.fat_sectors_short   = s_tdata[127:112];
        bpb.fat_sectors_long    = s_tdata[159:128];
        bpb.root_first_cluster  = s_tdata[191:160];
        bpb.partition_start     = s_tdata[223:192];
    end

    fvg_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_bpb           (bpb),
        .out_valid        (fr_valid),
        .out_ready        (fr_ready),
        .out_data_sectors (fr_data_sectors),
        .out_spc          (fr_spc),
        .out_side         (fr_side)
    );

    fvg_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (fr_valid),
        .in_ready     (fr_ready),
        .in_dividend  (fr_data_sectors),
        .in_divisor   (fr_spc),
        .in_side      (fr_side),
        .out_valid    (dv_valid),
        .out_ready    (dv_ready),
        .out_quotient (dv_quotient),
        .out_side     (dv_side)
    );

    fvg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (dv_valid),
        .in_ready    (dv_ready),
        .in_clusters (dv_quotient),
        .in_side     (dv_side),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    // Output packing
    assign m_tdata = {3'd0, result.end_mark, result.root_dir_sectors, result.data_start,
                      result.root_start, result.fat_start, result.cluster_total};
    assign m_tuser = {result.fat_kind, result.status};

`ifndef SYNTHESIS
    // A good volume is never reported as FAT12
    a_ok_not_fat12: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == fvg_pkg::ST_OK)
        |-> (m_tuser[3:2] == fvg_pkg::KIND_FAT16 || m_tuser[3:2] == fvg_pkg::KIND_FAT32))
        else $error("ok status with FAT12 kind");

    // Header errors clear every other result field
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] == fvg_pkg::ST_BAD_SECTOR
                      || m_tuser[1:0] == fvg_pkg::ST_ZERO_CLUSTER))
        |-> (m_tdata == '0 && m_tuser[3:2] == fvg_pkg::KIND_FAT12))
        else $error("error result carries nonzero fields");

    // End mark follows the FAT type
    a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == fvg_pkg::ST_OK)
        |-> ((m_tuser[3:2] == fvg_pkg::KIND_FAT16
              && m_tdata[164:141] == 24'(fvg_pkg::EOC_FAT16))
             || (m_tuser[3:2] == fvg_pkg::KIND_FAT32
                 && m_tdata[164:141] == 24'(fvg_pkg::EOC_FAT32))))
        else $error("end mark does not match FAT type");

    // Classification agrees with the cluster count
    a_kind_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3:2] == fvg_pkg::KIND_FAT32)
        |-> (m_tdata[31:0] >= 32'(fvg_pkg::FAT16_LIMIT)))
        else $error("FAT32 kind below cluster limit");
`endif

endmodule
